// ===== rtl/core/serial_line_editor_core_macros.svh =====
// Assertion macros shared by the serial line editor checker.
// Every macro samples on clk and is disabled while rst is high.
`ifndef SERIAL_LINE_EDITOR_CORE_MACROS_SVH
`define SERIAL_LINE_EDITOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sle_pkg.sv =====
// Package of the serial line editor: character codes, result kinds, register map,
// queue entry and configuration types. No dependencies.
package sle_pkg;

  // Character codes the editor reacts to.
  localparam logic [7:0] CH_XON   = 8'h11;
  localparam logic [7:0] CH_XOFF  = 8'h13;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Event codes on the cmd field.
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_IDLE = 1'b1;

  // Result kinds.
  localparam logic [2:0] K_ECHO    = 3'd0;
  localparam logic [2:0] K_STORE   = 3'd1;
  localparam logic [2:0] K_DONE    = 3'd2;
  localparam logic [2:0] K_ABORT   = 3'd3;
  localparam logic [2:0] K_TIMEOUT = 3'd4;

  // Register map: index is paddr bit 2.
  localparam int         ADDR_W         = 3;
  localparam logic       REG_LINE_SIZE  = 1'b0;
  localparam logic       REG_IDLE_LIMIT = 1'b1;
  localparam logic [7:0]  LINE_SIZE_RST  = 8'd80;
  localparam logic [31:0] IDLE_LIMIT_RST = 32'd100000000;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Operation decided by the front end.
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_IGNORE,
    OP_BS,
    OP_ESC,
    OP_CR,
    OP_LF,
    OP_CHAR
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } q_entry_t;

  typedef struct packed {
    logic [7:0]  line_size;
    logic [31:0] idle_limit;
  } cfg_t;

endpackage

// ===== rtl/core/sle_ifs.sv =====
// Handshake channels of the serial line editor: input events and result words.
// Depends on nothing.

// Input event channel.
interface sle_evt_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_char;

  modport source (output valid, cmd, rx_char, input ready);
  modport sink   (input valid, cmd, rx_char, output ready);
endinterface

// Result channel.
interface sle_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] char_out;
  logic [7:0] position;
  logic       last;

  modport source (output valid, kind, char_out, position, last, input ready);
  modport sink   (input valid, kind, char_out, position, last, output ready);
endinterface

// ===== rtl/core/sle_regs.sv =====
// APB-style configuration registers of the serial line editor.
// Depends on sle_pkg.
module sle_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sle_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output sle_pkg::cfg_t             cfg
);

  logic [7:0]  line_size;
  logic [31:0] idle_limit;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_size  <= sle_pkg::LINE_SIZE_RST;
      idle_limit <= sle_pkg::IDLE_LIMIT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        sle_pkg::REG_LINE_SIZE:  line_size  <= pwdata[7:0];
        sle_pkg::REG_IDLE_LIMIT: idle_limit <= pwdata;
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    unique case (paddr[2])
      sle_pkg::REG_LINE_SIZE:  prdata = {24'd0, line_size};
      sle_pkg::REG_IDLE_LIMIT: prdata = idle_limit;
      default:                 prdata = '0;
    endcase
  end

  assign cfg.line_size  = line_size;
  assign cfg.idle_limit = idle_limit;

endmodule

// ===== rtl/core/sle_front.sv =====
// Front end of the serial line editor: accepts event words and classifies them
// into queue entries. Depends on sle_pkg and sle_ifs.
module sle_front (
  sle_evt_if.sink           evt,
  input  logic              space,
  output logic              push,
  output sle_pkg::q_entry_t push_data
);

  // Accept whenever the queue has room.
  assign evt.ready = space;
  assign push      = evt.valid && space;

  // Map the event onto an operation for the back end.
  always_comb begin
    push_data.ch = evt.rx_char;
    if (evt.cmd == sle_pkg::CMD_IDLE) begin
      push_data.op = sle_pkg::OP_IDLE;
    end else begin
      unique case (evt.rx_char)
        sle_pkg::CH_XON, sle_pkg::CH_XOFF: push_data.op = sle_pkg::OP_IGNORE;
        sle_pkg::CH_BS, sle_pkg::CH_DEL:   push_data.op = sle_pkg::OP_BS;
        sle_pkg::CH_ESC:                   push_data.op = sle_pkg::OP_ESC;
        sle_pkg::CH_CR:                    push_data.op = sle_pkg::OP_CR;
        sle_pkg::CH_LF:                    push_data.op = sle_pkg::OP_LF;
        default:                           push_data.op = sle_pkg::OP_CHAR;
      endcase
    end
  end

endmodule

// ===== rtl/core/sle_queue.sv =====
// Small FIFO of classified operations between the front and back ends.
// Depends on sle_pkg.
module sle_queue #(
  parameter int DEPTH = sle_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sle_pkg::q_entry_t push_data,
  output logic              space,
  input  logic              pop,
  output logic              avail,
  output sle_pkg::q_entry_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sle_pkg::q_entry_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign space    = count != CNT_W'(DEPTH);
  assign avail    = count != '0;
  assign pop_data = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/sle_back.sv =====
// Back end of the serial line editor: holds the character and idle counts and
// steps each operation through its result words. Depends on sle_pkg and sle_ifs.
module sle_back (
  input  logic              clk,
  input  logic              rst,
  input  sle_pkg::cfg_t     cfg,
  input  logic              avail,
  input  sle_pkg::q_entry_t pop_data,
  output logic              pop,
  sle_res_if.source         res
);

  // Current operation and its step.
  logic              act;
  sle_pkg::q_entry_t cur;
  logic [1:0]        step;

  // Editor state.
  logic [7:0]  char_count;
  logic [31:0] idle_count;

  // Output register.
  logic       res_valid;
  logic [2:0] res_kind;
  logic [7:0] res_char;
  logic [7:0] res_pos;
  logic       res_last;

  // Decoded step.
  logic        emit;
  logic        fin;
  logic [2:0]  r_kind;
  logic [7:0]  r_char;
  logic [7:0]  r_pos;
  logic [7:0]  char_count_next;
  logic [31:0] idle_count_next;
  logic [31:0] idle_inc;
  logic [7:0]  limit;
  logic        at_limit;
  logic        out_free;
  logic        advance;

  assign limit    = (cfg.line_size >= 8'd3) ? cfg.line_size - 8'd2 : 8'd1;
  assign at_limit = char_count >= limit;
  assign idle_inc = idle_count + 32'd1;
  assign out_free = !res_valid || res.ready;
  assign advance  = act && out_free;
  assign pop      = avail && (!act || (advance && fin));

  // At most one result word per step; fin marks the final step of the operation.
  always_comb begin
    emit            = 1'b0;
    fin             = 1'b0;
    r_kind          = sle_pkg::K_ECHO;
    r_char          = 8'd0;
    r_pos           = 8'd0;
    char_count_next = char_count;
    idle_count_next = 32'd0;
    unique case (cur.op)
      sle_pkg::OP_IDLE: begin
        fin = 1'b1;
        if (idle_inc == cfg.idle_limit) begin
          emit            = 1'b1;
          r_kind          = sle_pkg::K_TIMEOUT;
          char_count_next = 8'd0;
        end else begin
          idle_count_next = idle_inc;
        end
      end
      sle_pkg::OP_IGNORE: begin
        fin = 1'b1;
        if (at_limit) begin
          emit            = 1'b1;
          r_kind          = sle_pkg::K_DONE;
          r_pos           = char_count;
          char_count_next = 8'd0;
        end
      end
      sle_pkg::OP_ESC: begin
        fin             = 1'b1;
        emit            = 1'b1;
        r_kind          = sle_pkg::K_ABORT;
        r_pos           = char_count;
        char_count_next = 8'd0;
      end
      sle_pkg::OP_BS: begin
        unique case (step)
          2'd0: begin
            // An empty line has nothing to erase and cannot be at its limit.
            if (char_count == 8'd0) begin
              fin = 1'b1;
            end else begin
              emit            = 1'b1;
              r_char          = sle_pkg::CH_BS;
              char_count_next = char_count - 8'd1;
            end
          end
          2'd1: begin
            emit   = 1'b1;
            r_char = sle_pkg::CH_SPACE;
          end
          2'd2: begin
            emit   = 1'b1;
            r_char = sle_pkg::CH_BS;
            fin    = !at_limit;
          end
          default: begin
            emit            = 1'b1;
            fin             = 1'b1;
            r_kind          = sle_pkg::K_DONE;
            r_pos           = char_count;
            char_count_next = 8'd0;
          end
        endcase
      end
      sle_pkg::OP_CR: begin
        emit = 1'b1;
        unique case (step)
          2'd0: begin
            r_kind          = sle_pkg::K_STORE;
            r_char          = sle_pkg::CH_CR;
            r_pos           = char_count;
            char_count_next = char_count + 8'd1;
          end
          2'd1: begin
            r_kind          = sle_pkg::K_STORE;
            r_char          = sle_pkg::CH_LF;
            r_pos           = char_count;
            char_count_next = char_count + 8'd1;
          end
          2'd2: begin
            r_char = sle_pkg::CH_LF;
          end
          default: begin
            fin             = 1'b1;
            r_kind          = sle_pkg::K_DONE;
            r_pos           = char_count;
            char_count_next = 8'd0;
          end
        endcase
      end
      default: begin
        // Plain character or LF: store, echo, then maybe end the line.
        emit = 1'b1;
        unique case (step)
          2'd0: begin
            r_kind          = sle_pkg::K_STORE;
            r_char          = cur.ch;
            r_pos           = char_count;
            char_count_next = char_count + 8'd1;
          end
          2'd1: begin
            r_char = cur.ch;
            fin    = (cur.op == sle_pkg::OP_CHAR) && !at_limit;
          end
          default: begin
            fin             = 1'b1;
            r_kind          = sle_pkg::K_DONE;
            r_pos           = char_count;
            char_count_next = 8'd0;
          end
        endcase
      end
    endcase
  end

  // Sequencer and editor state.
  always_ff @(posedge clk) begin
    if (rst) begin
      act        <= 1'b0;
      step       <= 2'd0;
      char_count <= 8'd0;
      idle_count <= 32'd0;
    end else begin
      if (advance) begin
        char_count <= char_count_next;
        idle_count <= idle_count_next;
      end
      // A pop starts the next operation; it only comes once the current one is done.
      if (pop) begin
        act  <= 1'b1;
        step <= 2'd0;
      end else if (advance) begin
        step <= fin ? 2'd0 : step + 2'd1;
        if (fin) begin
          act <= 1'b0;
        end
      end
    end
  end

  // Operation register.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_data;
    end
  end

  // Output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= advance && emit;
    end
  end

  // Output word.
  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_kind <= r_kind;
      res_char <= r_char;
      res_pos  <= r_pos;
      res_last <= fin;
    end
  end

  assign res.valid    = res_valid;
  assign res.kind     = res_kind;
  assign res.char_out = res_char;
  assign res.position = res_pos;
  assign res.last     = res_last;

endmodule

// ===== rtl/core/serial_line_editor_core.sv =====
// Top level of the serial line editor: registers, front end, queue and back end.
// Depends on sle_pkg, sle_ifs, sle_regs, sle_front, sle_queue and sle_back.
//
//   channel  | direction | handshake       | word
//   evt      | in        | valid / ready   | cmd, rx_char
//   res      | out       | valid / ready   | kind, char_out, position, last
//   apb      | in / out  | psel / penable  | paddr, pwdata, prdata (pready tied high)
//
// The back end emits at most one result word per cycle, held while res stalls; an event
// causes n words (0 to 4), which the back-end sequencer steps through one after another.
// The front end takes a new event every cycle while the queue has room.
// A stall on res holds the back end only; the queue keeps accepting until full.
// Synchronous reset clears the counts, the queue and the output valid.
module serial_line_editor_core #(
  parameter int QUEUE_DEPTH = sle_pkg::QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  sle_evt_if.sink                   evt,
  sle_res_if.source                 res,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sle_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  sle_pkg::cfg_t     cfg;
  logic              space;
  logic              push;
  sle_pkg::q_entry_t push_data;
  logic              pop;
  logic              avail;
  sle_pkg::q_entry_t pop_data;

  // Configuration registers.
  sle_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Classification of incoming events.
  sle_front u_front (
    .evt       (evt),
    .space     (space),
    .push      (push),
    .push_data (push_data)
  );

  // Decoupling queue.
  sle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .space     (space),
    .pop       (pop),
    .avail     (avail),
    .pop_data  (pop_data)
  );

  // Execution and result words.
  sle_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .avail    (avail),
    .pop_data (pop_data),
    .pop      (pop),
    .res      (res)
  );

endmodule

// ===== rtl/core/sle_checker.sv =====
// Port-level checks of the serial line editor, bound to its top level.
// Depends on sle_pkg and serial_line_editor_core_macros.svh.
`include "serial_line_editor_core_macros.svh"

module sle_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [2:0] kind,
  input logic [7:0] char_out,
  input logic [7:0] position,
  input logic       last,
  input logic       pready
);

  logic end_word;

  assign end_word = (kind == sle_pkg::K_DONE) || (kind == sle_pkg::K_ABORT) ||
                    (kind == sle_pkg::K_TIMEOUT);

  // The configuration port never waits.
  `SLE_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")

  // A stalled result word keeps its contents.
  `SLE_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(kind) && $stable(char_out) && $stable(position) && $stable(last), "stalled result changed")

  // Only defined kinds come out.
  `SLE_ASSERT_NOW(a_kind_range, res_valid, kind <= sle_pkg::K_TIMEOUT, "undefined result kind")

  // Line end, abort and timeout close the event and carry no character.
  `SLE_ASSERT_NOW(a_end_last, res_valid && end_word, last && (char_out == 8'd0), "end word malformed")

  // Echo words carry no buffer position.
  `SLE_ASSERT_NOW(a_echo_pos, res_valid && (kind == sle_pkg::K_ECHO), position == 8'd0, "echo with position")

endmodule

bind serial_line_editor_core sle_checker u_sle_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .kind      (res.kind),
  .char_out  (res.char_out),
  .position  (res.position),
  .last      (res.last),
  .pready    (pready)
);

// ===== tb/tb.sv =====
// Self-checking testbench for serial_line_editor_core: drives events and APB writes.
// A scoreboard class predicts result words; depends on sle_pkg and sle_ifs.
`timescale 1ns / 1ps

module tb;

  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_EVENTS   = 29;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] char_out;
    logic [7:0] position;
    logic       last;
  } res_word_t;

  // Predicts the result words of each accepted event and checks the words that come out.
  class line_editor_scoreboard;
    logic [7:0]  line_size;
    logic [31:0] idle_limit;
    logic [7:0]  char_count;
    logic [31:0] idle_count;
    res_word_t   expected_words[$];
    int          errors;

    function new();
      line_size  = sle_pkg::LINE_SIZE_RST;
      idle_limit = sle_pkg::IDLE_LIMIT_RST;
      char_count = '0;
      idle_count = '0;
      errors     = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void push_word(logic [2:0] kind, logic [7:0] ch, logic [7:0] pos);
      res_word_t w;
      w.kind     = kind;
      w.char_out = ch;
      w.position = pos;
      w.last     = 1'b0;
      expected_words.push_back(w);
    endfunction

    // Works out the words one accepted event causes and queues them.
    function void note_event(logic cmd, logic [7:0] ch);
      int         first;
      logic [7:0] count_limit;
      bit         ends;
      first       = expected_words.size();
      count_limit = (line_size >= 8'd3) ? line_size - 8'd2 : 8'd1;
      ends        = 1'b0;
      if (cmd == sle_pkg::CMD_IDLE) begin
        idle_count = idle_count + 32'd1;
        if (idle_count == idle_limit) begin
          idle_count = '0;
          char_count = '0;
          push_word(sle_pkg::K_TIMEOUT, 8'h00, 8'h00);
        end
      end else begin
        idle_count = '0;
        case (ch)
          sle_pkg::CH_XON, sle_pkg::CH_XOFF: begin
          end
          sle_pkg::CH_BS, sle_pkg::CH_DEL: begin
            if (char_count != 8'd0) begin
              char_count = char_count - 8'd1;
              push_word(sle_pkg::K_ECHO, sle_pkg::CH_BS, 8'h00);
              push_word(sle_pkg::K_ECHO, sle_pkg::CH_SPACE, 8'h00);
              push_word(sle_pkg::K_ECHO, sle_pkg::CH_BS, 8'h00);
            end
          end
          sle_pkg::CH_ESC: begin
            push_word(sle_pkg::K_ABORT, 8'h00, char_count);
            char_count = '0;
          end
          sle_pkg::CH_CR: begin
            push_word(sle_pkg::K_STORE, sle_pkg::CH_CR, char_count);
            char_count = char_count + 8'd1;
            push_word(sle_pkg::K_STORE, sle_pkg::CH_LF, char_count);
            push_word(sle_pkg::K_ECHO, sle_pkg::CH_LF, 8'h00);
            char_count = char_count + 8'd1;
            ends = 1'b1;
          end
          default: begin
            push_word(sle_pkg::K_STORE, ch, char_count);
            push_word(sle_pkg::K_ECHO, ch, 8'h00);
            char_count = char_count + 8'd1;
            if (ch == sle_pkg::CH_LF) ends = 1'b1;
          end
        endcase
        // Abort never falls through to the line end test.
        if (ch != sle_pkg::CH_ESC && (ends || char_count >= count_limit)) begin
          push_word(sle_pkg::K_DONE, 8'h00, char_count);
          char_count = '0;
        end
      end
      if (expected_words.size() > first)
        expected_words[expected_words.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    // Compares one accepted result word with the oldest prediction.
    function void check_word(logic [2:0] kind, logic [7:0] ch, logic [7:0] pos, logic last);
      res_word_t w;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: kind %0d char 0x%0h", kind, ch);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      compare_field("kind", int'(w.kind), int'(kind));
      compare_field("char_out", int'(w.char_out), int'(ch));
      compare_field("position", int'(w.position), int'(pos));
      compare_field("last", int'(w.last), int'(last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [sle_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sle_evt_if evt_ch ();
  sle_res_if res_ch ();

  line_editor_scoreboard sb;
  int quiet_cycles = 0;
  int burst_left;
  int stall_mode   = 0;
  int stall_timer  = 0;

  serial_line_editor_core dut (
    .clk     (clk),
    .rst     (rst),
    .evt     (evt_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sample both channels at the rising edge; results first, since a word never
  // comes from an event accepted at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready)
        sb.check_word(res_ch.kind, res_ch.char_out, res_ch.position, res_ch.last);
      if (evt_ch.valid && evt_ch.ready)
        sb.note_event(evt_ch.cmd, evt_ch.rx_char);
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver stalls: always ready, random, or mostly stalled, switching now and then.
  always @(negedge clk) begin
    if (stall_timer == 0) begin
      stall_mode  = $urandom_range(0, 2);
      stall_timer = $urandom_range(20, 80);
    end else begin
      stall_timer = stall_timer - 1;
    end
    case (stall_mode)
      0: res_ch.ready = 1'b1;
      1: res_ch.ready = 1'($urandom_range(0, 1));
      default: res_ch.ready = (stall_timer % 4 == 0);
    endcase
  end

  // Offers one event and returns at the falling edge after it is taken.
  // The sender works in bursts; valid may drop between bursts.
  task automatic send_event(input logic cmd, input logic [7:0] ch);
    int gap;
    evt_ch.valid   = 1'b1;
    evt_ch.cmd     = cmd;
    evt_ch.rx_char = ch;
    do @(posedge clk); while (!evt_ch.ready);
    @(negedge clk);
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = $urandom_range(0, 7);
      if (gap != 0) begin
        evt_ch.valid   = 1'b0;
        evt_ch.rx_char = 8'($urandom_range(0, 255));
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_event(sle_pkg::CMD_CHAR, ch);
  endtask

  task automatic send_idle();
    send_event(sle_pkg::CMD_IDLE, 8'($urandom_range(0, 255)));
  endtask

  // Holds the sender until every predicted word has come out.
  task automatic wait_results();
    evt_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic apb_access(input logic write, input logic idx, input logic [31:0] data,
                            output logic [31:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic read_check(input logic idx, input logic [31:0] exp_val);
    logic [31:0] rdata;
    apb_access(1'b0, idx, 32'h0, rdata);
    if (rdata !== exp_val) begin
      $error("register %0d: expected 0x%0h, got 0x%0h", idx, exp_val, rdata);
      sb.errors++;
    end
  endtask

  // Writes both registers while the block is idle, then reads them back.
  // Events with no words may still be in flight, so let the pipeline settle first.
  task automatic set_config(input logic [7:0] size_val, input logic [31:0] limit_val);
    logic [31:0] rdata;
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    apb_access(1'b1, sle_pkg::REG_LINE_SIZE, {24'h0, size_val}, rdata);
    sb.line_size = size_val;
    apb_access(1'b1, sle_pkg::REG_IDLE_LIMIT, limit_val, rdata);
    sb.idle_limit = limit_val;
    read_check(sle_pkg::REG_LINE_SIZE, {24'h0, size_val});
    read_check(sle_pkg::REG_IDLE_LIMIT, limit_val);
  endtask

  // Mostly printable text that builds lines, with editing keys, idle polls and noise.
  task automatic send_random_event();
    int r;
    r = $urandom_range(0, 99);
    if (r < 58)      send_char(8'($urandom_range(8'h20, 8'h7E)));
    else if (r < 62) send_char(sle_pkg::CH_BS);
    else if (r < 66) send_char(sle_pkg::CH_DEL);
    else if (r < 70) send_char(sle_pkg::CH_CR);
    else if (r < 72) send_char(sle_pkg::CH_LF);
    else if (r < 75) send_char(sle_pkg::CH_ESC);
    else if (r < 77) send_char(($urandom_range(0, 1) != 0) ? sle_pkg::CH_XON : sle_pkg::CH_XOFF);
    else if (r < 86) send_char(8'($urandom_range(0, 255)));
    else             send_idle();
  endtask

  initial begin
    logic [7:0]  size_val;
    logic [31:0] limit_val;
    sb             = new();
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    evt_ch.valid   = 1'b0;
    evt_ch.cmd     = sle_pkg::CMD_CHAR;
    evt_ch.rx_char = 8'h00;
    burst_left     = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset values of the registers.
    read_check(sle_pkg::REG_LINE_SIZE, {24'h0, sle_pkg::LINE_SIZE_RST});
    read_check(sle_pkg::REG_IDLE_LIMIT, sle_pkg::IDLE_LIMIT_RST);

    // Directed: byte extremes, editing, abort, line ends and the idle timeout.
    set_config(8'd80, 32'd3);
    send_char(8'h41);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h80);
    send_char(sle_pkg::CH_BS);
    send_char(sle_pkg::CH_DEL);
    send_char(sle_pkg::CH_XON);
    send_char(sle_pkg::CH_XOFF);
    send_char(sle_pkg::CH_ESC);
    send_char(sle_pkg::CH_BS);
    send_char(8'h68);
    send_char(8'h69);
    send_char(sle_pkg::CH_CR);
    send_char(sle_pkg::CH_LF);
    send_idle();
    send_idle();
    send_idle();
    send_char(8'h78);
    send_idle();
    send_char(sle_pkg::CH_SPACE);
    send_idle();
    send_idle();
    send_idle();

    // Smallest legal line size: every character ends the line.
    set_config(8'd3, 32'd1);
    send_char(8'h61);
    send_char(sle_pkg::CH_BS);
    send_char(sle_pkg::CH_CR);
    send_idle();

    // Line size lowered in the middle of a line: even an ignored key ends it.
    set_config(8'd255, 32'd1);
    send_char(8'h61);
    send_char(8'h62);
    send_char(8'h63);
    set_config(8'd4, 32'd1);
    send_char(sle_pkg::CH_XON);
    send_idle();

    // Line size below three falls back to a limit of one.
    set_config(8'd2, 32'hFFFF_FFFF);
    send_char(8'h71);
    send_idle();

    // Random phases, each with its own register settings.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 3))
        0: size_val = 8'd3;
        1: size_val = 8'd255;
        2: size_val = 8'($urandom_range(3, 20));
        default: size_val = 8'($urandom_range(4, 80));
      endcase
      case ($urandom_range(0, 2))
        0: limit_val = 32'd1;
        1: limit_val = 32'hFFFF_FFFF;
        default: limit_val = $urandom_range(2, 8);
      endcase
      set_config(size_val, limit_val);
      for (int n = 0; n < PHASE_EVENTS; n++) begin
        send_random_event();
        if ($urandom_range(0, 39) == 0) wait_results();
      end
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/sle_pkg.sv
rtl/core/sle_ifs.sv
rtl/core/sle_regs.sv
rtl/core/sle_front.sv
rtl/core/sle_queue.sv
rtl/core/sle_back.sv
rtl/core/serial_line_editor_core.sv
rtl/core/sle_checker.sv
tb/tb.sv
